// ===== rtl/dds_pkg.sv =====
package dds_pkg;

	// Phase accumulator and table geometry
	localparam int PHASE_WIDTH = 32;
	localparam int TABLE_ADDR_BITS = 12;
	localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);
	localparam int ROM_AW = TABLE_ADDR_BITS - 1;
	localparam int SINE_W = 15;

	// Configuration port
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int STEP_W = 32;
	localparam int WAVE_W = 2;
	localparam int AMP_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd3;

	localparam logic [WAVE_W-1:0] WAVE_SINE = 2'd0;
	localparam logic [WAVE_W-1:0] WAVE_SAW = 2'd1;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd2;

	// Datapath widths
	localparam int DAC_W = 15;
	localparam int OP_W = 16;
	localparam int PROD_W = AMP_W + OP_W;
	localparam int K_W = 13;
	localparam int SCALED_W = PROD_W + K_W;
	localparam int V_W = 17;
	localparam int M_W = 18;
	localparam int RECIP_W = 16;
	localparam int QUO_W = 16;

	localparam logic [DAC_W-1:0] DAC_CENTRE = 15'd14270;

	// Per-waveform scale factors and the power-of-two part of each divisor.
	localparam logic signed [K_W-1:0] K_SINE = 13'sd1982;
	localparam logic signed [K_W-1:0] K_SAW = -13'sd3964;
	localparam logic signed [K_W-1:0] K_SQUARE = 13'sd396;
	localparam int SINE_SHIFT = 23;
	localparam int SAW_SHIFT = TABLE_ADDR_BITS + 8;
	localparam int SQUARE_SHIFT = 8;

	localparam logic [TABLE_ADDR_BITS-1:0] SQUARE_SPLIT =
		TABLE_ADDR_BITS'((2098 << TABLE_ADDR_BITS) >> 12);

	// Floor division by five: bias the value positive, multiply by the
	// reciprocal, then remove the bias from the quotient.
	localparam int DIV_BIAS = 8192;
	localparam logic [M_W-1:0] DIV_BIAS_X5 = M_W'(5 * DIV_BIAS);
	localparam logic signed [QUO_W-1:0] DIV_BIAS_Q = QUO_W'(DIV_BIAS);
	localparam logic [RECIP_W-1:0] RECIP_5 = 16'd52429;
	localparam int RECIP_SHIFT = 18;

	typedef logic [SINE_W-1:0] qsine_rom_t [0:QUARTER];

	// Quarter-wave sine in unsigned Q0.15 from an odd Taylor series up to x^11,
	// evaluated in unsigned Q2.30 with truncation.
	function automatic logic [SINE_W-1:0] quarter_sine(longint unsigned q);
		longint unsigned one;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		one = 64'd1073741824;
		x = (q * 64'd1686629713) >> (TABLE_ADDR_BITS - 2);
		x2 = (x * x) >> 30;
		t = one - x2 / 64'd110;
		t = one - ((x2 * t) >> 30) / 64'd72;
		t = one - ((x2 * t) >> 30) / 64'd42;
		t = one - ((x2 * t) >> 30) / 64'd20;
		t = one - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		if (s > one) begin
			s = one;
		end
		return SINE_W'((s * 64'd32767 + 64'd536870912) >> 30);
	endfunction

	function automatic qsine_rom_t build_qsine();
		qsine_rom_t rom;
		for (int k = 0; k <= QUARTER; k++) begin
			rom[k] = quarter_sine(longint'(k));
		end
		return rom;
	endfunction

	localparam qsine_rom_t QSINE_ROM = build_qsine();

endpackage

// ===== rtl/dds_waveform_generator.sv =====
// Direct digital synthesizer with a 32-bit phase accumulator.
// Input stream: each beat carries tick in tdata[0]. A beat with tick set,
// taken while the enable register is set, advances the phase by phase_step
// and yields one DAC word; any other beat is consumed without a result.
// Output stream: one beat per such tick, dac_word in tdata[14:0].
// Configuration: cfg_we/cfg_addr/cfg_wdata write phase_step (0), waveform (1),
// amplitude (2) and enable (3); the user must write them only while the block
// is idle; the block does not enforce this. A tick passes the phase add, sine
// ROM read, amplitude multiply, scale multiply, divisor shift and reciprocal
// divide by five (not for square) into the output register. One beat per
// cycle is sustained while the receiver is ready; each stage holds one item.
// When the receiver stalls, results queue in the empty stages; the input stops
// being ready only once every stage and the output register are full. Reset
// clears the phase, all configuration registers and all stage valid bits; the
// block comes out disabled with a zero phase step.
module dds_waveform_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] tick, [7:1] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [14:0] dac_word, [15] zero
	input  logic                             cfg_we,
	input  logic [dds_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [dds_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int PW = dds_pkg::PHASE_WIDTH;
	localparam int TAB = dds_pkg::TABLE_ADDR_BITS;

	// Configuration registers
	logic [dds_pkg::STEP_W-1:0]        phase_step_q;
	logic [dds_pkg::WAVE_W-1:0]        waveform_q;
	logic signed [dds_pkg::AMP_W-1:0]  amplitude_q;
	logic                              enable_q;

	logic [PW-1:0] phase_acc_q;
	logic [PW-1:0] phase_next;
	logic          fire;

	// Stage valid bits and load enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, out_valid_q;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_out;

	// Stage payloads
	logic [TAB-1:0]                        idx_s1, idx_s2;
	logic                                  neg_s2;
	logic [dds_pkg::SINE_W-1:0]            rom_s2;
	logic signed [dds_pkg::PROD_W-1:0]     prod_s3;
	logic signed [dds_pkg::SCALED_W-1:0]   scaled_s4;
	logic signed [dds_pkg::V_W-1:0]        v_s5;
	logic [dds_pkg::M_W-1:0]               m_s5;
	logic [dds_pkg::DAC_W-1:0]             dac_q;

	// Combinational datapath
	logic [dds_pkg::ROM_AW-1:0]            rom_addr;
	logic signed [dds_pkg::OP_W-1:0]       op;
	logic signed [dds_pkg::OP_W-1:0]       sine_val;
	logic signed [dds_pkg::K_W-1:0]        kconst;
	logic signed [dds_pkg::SCALED_W-1:0]   shifted;
	logic [dds_pkg::M_W+dds_pkg::RECIP_W-1:0] recip_prod;
	logic signed [dds_pkg::QUO_W-1:0]      quo;
	logic signed [dds_pkg::QUO_W-1:0]      offset;

	// A stage may load when it is empty or its content moves on this cycle.
	assign ld_out = !out_valid_q || m_axis_tready;
	assign ld_s5 = !vld_s5 || ld_out;
	assign ld_s4 = !vld_s4 || ld_s5;
	assign ld_s3 = !vld_s3 || ld_s4;
	assign ld_s2 = !vld_s2 || ld_s3;
	assign ld_s1 = !vld_s1 || ld_s2;

	assign s_axis_tready = ld_s1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, dac_q};

	assign fire = s_axis_tvalid && s_axis_tready && s_axis_tdata[0] && enable_q;
	assign phase_next = phase_acc_q + PW'(phase_step_q);

	// Odd quadrants read the quarter table backwards.
	always_comb begin
		if (idx_s1[TAB-2]) begin
			rom_addr = dds_pkg::ROM_AW'(dds_pkg::QUARTER) - {1'b0, idx_s1[TAB-3:0]};
		end else begin
			rom_addr = {1'b0, idx_s1[TAB-3:0]};
		end
	end

	always_comb begin
		sine_val = neg_s2 ? -dds_pkg::OP_W'({1'b0, rom_s2}) : dds_pkg::OP_W'({1'b0, rom_s2});
		case (waveform_q)
			dds_pkg::WAVE_SINE: begin
				op = sine_val;
				kconst = dds_pkg::K_SINE;
			end
			dds_pkg::WAVE_SAW: begin
				op = dds_pkg::OP_W'({1'b0, idx_s2});
				kconst = dds_pkg::K_SAW;
			end
			dds_pkg::WAVE_SQUARE: begin
				op = (idx_s2 < dds_pkg::SQUARE_SPLIT) ? 16'sd1 : -16'sd1;
				kconst = dds_pkg::K_SQUARE;
			end
			default: begin
				op = '0;
				kconst = '0;
			end
		endcase
	end

	always_comb begin
		case (waveform_q)
			dds_pkg::WAVE_SINE: shifted = scaled_s4 >>> dds_pkg::SINE_SHIFT;
			dds_pkg::WAVE_SAW:  shifted = scaled_s4 >>> dds_pkg::SAW_SHIFT;
			default:            shifted = scaled_s4 >>> dds_pkg::SQUARE_SHIFT;
		endcase
	end

	always_comb begin
		recip_prod = (dds_pkg::M_W + dds_pkg::RECIP_W)'(m_s5) *
			(dds_pkg::M_W + dds_pkg::RECIP_W)'(dds_pkg::RECIP_5);
		quo = recip_prod[dds_pkg::RECIP_SHIFT +: dds_pkg::QUO_W];
		if (waveform_q == dds_pkg::WAVE_SQUARE) begin
			offset = dds_pkg::QUO_W'(v_s5);
		end else begin
			offset = quo - dds_pkg::DIV_BIAS_Q;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			waveform_q <= '0;
			amplitude_q <= '0;
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				dds_pkg::REG_PHASE_STEP: phase_step_q <= cfg_wdata[dds_pkg::STEP_W-1:0];
				dds_pkg::REG_WAVEFORM:   waveform_q <= cfg_wdata[dds_pkg::WAVE_W-1:0];
				dds_pkg::REG_AMPLITUDE:  amplitude_q <= cfg_wdata[dds_pkg::AMP_W-1:0];
				dds_pkg::REG_ENABLE:     enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Phase accumulator and stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_acc_q <= phase_next;
			end
			if (ld_s1) begin
				vld_s1 <= fire;
			end
			if (ld_s2) begin
				vld_s2 <= vld_s1;
			end
			if (ld_s3) begin
				vld_s3 <= vld_s2;
			end
			if (ld_s4) begin
				vld_s4 <= vld_s3;
			end
			if (ld_s5) begin
				vld_s5 <= vld_s4;
			end
			if (ld_out) begin
				out_valid_q <= vld_s5;
			end
		end
	end

	// Datapath registers; the sine table is read synchronously.
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			idx_s1 <= phase_next[PW-1 -: TAB];
		end
		if (ld_s2) begin
			idx_s2 <= idx_s1;
			neg_s2 <= idx_s1[TAB-1];
			rom_s2 <= dds_pkg::QSINE_ROM[rom_addr];
		end
		if (ld_s3) begin
			prod_s3 <= dds_pkg::PROD_W'(amplitude_q) * dds_pkg::PROD_W'(op);
		end
		if (ld_s4) begin
			scaled_s4 <= dds_pkg::SCALED_W'(prod_s3) * dds_pkg::SCALED_W'(kconst);
		end
		if (ld_s5) begin
			v_s5 <= dds_pkg::V_W'(shifted);
			m_s5 <= dds_pkg::M_W'(shifted) + dds_pkg::DIV_BIAS_X5;
		end
		if (ld_out) begin
			dac_q <= dds_pkg::DAC_CENTRE + dds_pkg::DAC_W'(offset);
		end
	end

	// The input only stalls when every stage holds an item.
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && out_valid_q))
		else $error("input stalled with an empty pipeline stage");

	// The phase only moves on an accepted tick while enabled.
	a_phase_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tvalid && s_axis_tready && s_axis_tdata[0] && enable_q)
		|=> $stable(phase_acc_q))
		else $error("phase accumulator moved without a tick");

	// A new result only comes from a filled last stage.
	a_out_from_s5: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_s5))
		else $error("output became valid from an empty stage");

endmodule
